### rtl/i2a_pkg.sv
// Shared types, codes and character constants for the integer-to-ASCII formatter.
// Used by integer_to_ascii_formatter and its bench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

    // Default width of the value to format
    localparam int VALUE_BITS_DEF = 32;

    // Width of one emitted character code
    localparam int CHAR_W = 7;

    // Format selector codes
    localparam logic [1:0] REQ_UDEC = 2'd0;
    localparam logic [1:0] REQ_SDEC = 2'd1;
    localparam logic [1:0] REQ_HEX  = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    // Fixed characters
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;

    // Digit to character, shared by decimal and hex output
    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
    };

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_PFX_ZERO,
        ST_PFX_X,
        ST_EMIT
    } i2a_state_t;

endpackage

`default_nettype wire

### rtl/i2a_dabble.sv
// One shift-and-add-3 step of binary to BCD conversion over all digits.
// Uses no package items; instantiated by integer_to_ascii_formatter.
`timescale 1ns / 1ps
`default_nettype none

module i2a_dabble #(
    parameter int DIGITS = 10
) (
    input  wire logic [4*DIGITS-1:0] bcd_in,
    input  wire logic                bit_in,
    output logic      [4*DIGITS-1:0] bcd_out
);

    logic [4*DIGITS-1:0] adj;

    // Add 3 to every digit of 5 or more, then shift in the next binary bit
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_in[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = bcd_in[4*i +: 4];
            end
        end
        bcd_out = {adj[4*DIGITS-2:0], bit_in};
    end

endmodule

`default_nettype wire

### rtl/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: sequencer, digit register, output word.
// Depends on i2a_pkg and i2a_dabble.
//
// Usage:
//   Slave channel s_* takes one word per value: s_tdata holds req_type
//   (bits 1:0, 0 unsigned decimal, 1 signed decimal, 2 hex) then value
//   (VALUE_BITS bits), zero padded to whole bytes. Master channel m_* gives
//   one character per word in m_tdata[6:0]; m_tlast marks the final one.
//   Decimal values pass through a shared shift-and-add-3 unit, one value bit
//   per cycle, then emit the sign if negative and the decimal digits from
//   the top, with leading zeros dropped unsent. Hex skips the converter and
//   emits the prefix 0x, then ceil(VALUE_BITS/4) digits with leading zeros.
//   req_type 3 is taken and yields nothing. s_tready is high only while the
//   sequencer is idle; the next value is taken while the final character
//   still waits in the output register. When m_tready is low, a valid output
//   word holds and the sequencer waits to emit its next character. Reset
//   clears the sequencer and the output valid; no word is lost or repeated
//   across a stall.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter
    import i2a_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // fields from bit 0: req_type[1:0], value[VALUE_BITS-1:0], zero pad
    input  wire logic [((VALUE_BITS+2+7)/8)*8-1:0]   s_tdata,

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // fields from bit 0: char_code[6:0], zero pad
    output logic [7:0]                               m_tdata,
    output logic                                     m_tlast
);

    // Decimal digits needed for 2^VALUE_BITS-1, hex digits for the value
    localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int HEX_W      = 4 * HEX_DIGITS;
    localparam int HEX_SHIFT  = BCD_W - HEX_W;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int DIG_W      = $clog2(DEC_DIGITS);

    i2a_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIG_W-1:0]      dig_reg, dig_next;
    logic                  neg_reg, neg_next;
    logic                  started_reg, started_next;

    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;

    logic [1:0]            req_type;
    logic [VALUE_BITS-1:0] value;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] mag;
    logic [BCD_W-1:0]      bcd_step;
    logic [3:0]            top_digit;
    logic                  out_free;
    logic                  is_last_digit;

    // Unpack the input word
    assign req_type = s_tdata[1:0];
    assign value    = s_tdata[VALUE_BITS+1:2];

    assign in_neg = (req_type == REQ_SDEC) && value[VALUE_BITS-1];
    assign mag    = in_neg ? (~value + VALUE_BITS'(1)) : value;

    // Shared binary to BCD step
    i2a_dabble #(
        .DIGITS (DEC_DIGITS)
    ) u_dabble (
        .bcd_in  (bcd_reg),
        .bit_in  (bin_reg[VALUE_BITS-1]),
        .bcd_out (bcd_step)
    );

    assign top_digit     = bcd_reg[BCD_W-1 -: 4];
    assign out_free      = !out_valid_reg || m_tready;
    assign is_last_digit = (dig_reg == '0);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

    // Hold state, digits and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // Sequence conversion and emit one character per free output slot
    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        dig_next       = dig_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (req_type)
                        REQ_UDEC, REQ_SDEC:
                        begin
                            bin_next     = mag;
                            bcd_next     = '0;
                            cnt_next     = '0;
                            neg_next     = in_neg;
                            started_next = 1'b0;
                            state_next   = ST_DABBLE;
                        end
                        REQ_HEX:
                        begin
                            bcd_next     = BCD_W'(value) << HEX_SHIFT;
                            dig_next     = DIG_W'(HEX_DIGITS - 1);
                            neg_next     = 1'b0;
                            started_next = 1'b1;
                            state_next   = ST_PFX_ZERO;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_DABBLE:
            begin
                bcd_next = bcd_step;
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_BITS - 1))
                begin
                    dig_next   = DIG_W'(DEC_DIGITS - 1);
                    state_next = ST_EMIT;
                end
            end

            ST_PFX_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CH_ZERO;
                    last_next      = 1'b0;
                    state_next     = ST_PFX_X;
                end
            end

            ST_PFX_X:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CH_X;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (neg_reg)
                begin
                    // Sign goes out ahead of the magnitude
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        char_next      = CH_MINUS;
                        last_next      = 1'b0;
                        neg_next       = 1'b0;
                    end
                end
                else if (!started_reg && (top_digit == 4'd0) && !is_last_digit)
                begin
                    // Drop a leading zero
                    bcd_next = bcd_reg << 4;
                    dig_next = dig_reg - DIG_W'(1);
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = DIGIT_CHARS[top_digit];
                    last_next      = is_last_digit;
                    started_next   = 1'b1;
                    bcd_next       = bcd_reg << 4;
                    dig_next       = dig_reg - DIG_W'(1);
                    if (is_last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### bench/integer_to_ascii_formatter_tb.sv
// Self-checking bench for integer_to_ascii_formatter: directed and random values in all
// three formats, checked character by character against a behavioral formatter.
// Depends on i2a_pkg and the formatter RTL.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;
    import i2a_pkg::*;

    localparam int VAL_W  = 32;
    localparam int DATA_W = ((VAL_W + 2 + 7) / 8) * 8;
    localparam int PAD_W  = DATA_W - VAL_W - 2;

    // One value to format, or a marker that holds the sender until the output drains
    typedef struct {
        logic [1:0]       req;
        logic [VAL_W-1:0] val;
        bit               wait_drain;
    } fmt_req_t;

    // One expected character word
    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tlast;

    fmt_req_t   pending [$];
    char_word_t chars_due [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int chars_checked = 0;
    int udec_sent = 0;
    int sdec_sent = 0;
    int hex_sent = 0;
    int none_sent = 0;

    integer_to_ascii_formatter #(
        .VALUE_BITS(VAL_W)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #4 clk = ~clk;

    // Build the text of one value and queue its characters
    function automatic void predict_text(input logic [1:0] req, input logic [VAL_W-1:0] val);
        logic [VAL_W-1:0]  mag;
        logic [CHAR_W-1:0] txt [$];
        logic [CHAR_W-1:0] digs [$];
        char_word_t        w;
        int                shift;
        int                i;
        txt = {};
        digs = {};
        if (req == REQ_UDEC || req == REQ_SDEC)
        begin
            mag = val;
            if (req == REQ_SDEC && val[VAL_W-1])
            begin
                txt.push_back(CH_MINUS);
                mag = -val;
            end
            if (mag == 0)
                digs.push_back(CH_ZERO);
            while (mag != 0)
            begin
                digs.push_front(DIGIT_CHARS[mag % 10]);
                mag = mag / 10;
            end
            for (i = 0; i < digs.size(); i++)
                txt.push_back(digs[i]);
        end
        else if (req == REQ_HEX)
        begin
            txt.push_back(CH_ZERO);
            txt.push_back(CH_X);
            for (shift = 4 * ((VAL_W + 3) / 4 - 1); shift >= 0; shift -= 4)
                txt.push_back(DIGIT_CHARS[(val >> shift) & 4'hF]);
        end
        for (i = 0; i < txt.size(); i++)
        begin
            w.code = txt[i];
            w.last = (i == txt.size() - 1);
            chars_due.push_back(w);
        end
    endfunction

    // Pick a format and a value, weighted toward digit-count and sign boundaries
    function automatic fmt_req_t random_request();
        fmt_req_t         r;
        logic [VAL_W-1:0] p;
        int               sel;
        int               m;
        r.wait_drain = 1'b0;
        m = $urandom_range(19);
        if (m < 6)
            r.req = REQ_UDEC;
        else if (m < 12)
            r.req = REQ_SDEC;
        else if (m < 18)
            r.req = REQ_HEX;
        else
            r.req = REQ_NONE;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2, 3: r.val = $urandom;
            4, 5:       r.val = $urandom_range(999);
            6:
            begin
                p = 1;
                repeat ($urandom_range(9)) p = p * 10;
                r.val = p + $urandom_range(2) - 1;
            end
            7:          r.val = 32'h8000_0000 + $urandom_range(4) - 2;
            8:          r.val = -$urandom_range(1000);
            default:    r.val = $urandom >> $urandom_range(31);
        endcase
        return r;
    endfunction

    task automatic add_value(input logic [1:0] req, input logic [VAL_W-1:0] val);
        fmt_req_t r;
        r.req = req;
        r.val = val;
        r.wait_drain = 1'b0;
        pending.push_back(r);
    endtask

    task automatic add_drain_hold();
        fmt_req_t r;
        r.req = REQ_NONE;
        r.val = '0;
        r.wait_drain = 1'b1;
        pending.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || chars_due.size() != 0)
            @(posedge clk);
    endtask

    // Drive input words; hold a presented word until it is taken
    always @(posedge clk or negedge rst_n)
    begin : drive
        fmt_req_t head;
        logic     take;
        logic     next_valid;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            take = s_tvalid && s_tready;
            if (take)
            begin
                head = pending.pop_front();
                predict_text(head.req, head.val);
                case (head.req)
                    REQ_UDEC: udec_sent++;
                    REQ_SDEC: sdec_sent++;
                    REQ_HEX:  hex_sent++;
                    default:  none_sent++;
                endcase
            end
            next_valid = s_tvalid && !take;
            if (!next_valid && pending.size() != 0)
            begin
                if (pending[0].wait_drain)
                begin
                    if (chars_due.size() == 0)
                        head = pending.pop_front();
                end
                else if ($urandom_range(99) >= send_idle_pct)
                begin
                    next_valid = 1'b1;
                    s_tdata <= {{PAD_W{1'b0}}, pending[0].val, pending[0].req};
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Check each output word against the oldest expected character; stall at random
    always @(posedge clk or negedge rst_n)
    begin : watch
        char_word_t due;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (chars_due.size() == 0)
                begin
                    $error("unexpected word: char_code %0h last_char %0b",
                           m_tdata[CHAR_W-1:0], m_tlast);
                    errors++;
                end
                else
                begin
                    due = chars_due.pop_front();
                    chars_checked++;
                    if (m_tdata[CHAR_W-1:0] !== due.code)
                    begin
                        $error("char_code: expected %0h, got %0h",
                               due.code, m_tdata[CHAR_W-1:0]);
                        errors++;
                    end
                    if (m_tlast !== due.last)
                    begin
                        $error("last_char: expected %0b, got %0b", due.last, m_tlast);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus: directed values, then random phases under different idling mixes
    initial
    begin : stimulus
        int       send_mix [4];
        int       recv_mix [4];
        int       ph;
        int       counted;
        int       hold_at;
        fmt_req_t r;
        send_mix = '{0, 52, 0, 37};
        recv_mix = '{0, 0, 52, 37};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes, every format, zero, most negative, ignored selector
        add_value(REQ_UDEC, 32'd0);
        add_value(REQ_UDEC, 32'd1);
        add_value(REQ_UDEC, 32'd9);
        add_value(REQ_UDEC, 32'd10);
        add_value(REQ_UDEC, 32'd999999999);
        add_value(REQ_UDEC, 32'd1000000000);
        add_value(REQ_UDEC, 32'hFFFF_FFFF);
        add_value(REQ_SDEC, 32'd0);
        add_value(REQ_SDEC, 32'd1);
        add_value(REQ_SDEC, 32'h7FFF_FFFF);
        add_value(REQ_SDEC, 32'h8000_0000);
        add_value(REQ_SDEC, 32'hFFFF_FFFF);
        add_value(REQ_SDEC, -32'sd10);
        add_drain_hold();
        add_value(REQ_HEX, 32'd0);
        add_value(REQ_HEX, 32'hFFFF_FFFF);
        add_value(REQ_HEX, 32'h0123_4567);
        add_value(REQ_HEX, 32'h89AB_CDEF);
        add_value(REQ_NONE, 32'hA5A5_5A5A);
        add_value(REQ_UDEC, 32'd42);
        add_value(REQ_NONE, 32'h0000_0000);
        add_value(REQ_SDEC, 32'h8000_0001);
        add_value(REQ_HEX, 32'h8000_0000);
        wait_idle();

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = send_mix[ph];
            recv_stall_pct = recv_mix[ph];
            counted = 0;
            hold_at = $urandom_range(20, 100);
            while (counted < 115)
            begin
                r = random_request();
                pending.push_back(r);
                counted++;
                if (counted == hold_at)
                begin
                    add_drain_hold();
                    hold_at = -1;
                end
            end
            wait_idle();
        end

        // Let any stray word show up before the verdict
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (60) @(posedge clk);
        if (chars_due.size() != 0)
        begin
            $error("%0d expected characters never arrived", chars_due.size());
            errors++;
        end
        $display("Formatted %0d unsigned, %0d signed and %0d hex values; %0d ignored selectors.",
                 udec_sent, sdec_sent, hex_sent, none_sent);
        $display("Checked %0d characters across four sender/receiver idling mixes.",
                 chars_checked);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Give up well past the slowest expected run
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### files.f
rtl/i2a_pkg.sv
rtl/i2a_dabble.sv
rtl/integer_to_ascii_formatter.sv
bench/integer_to_ascii_formatter_tb.sv
